[hdl/xlb_pkg.sv]
// Package for the GF(2) XOR linear basis block.
// Holds operation codes, fixed port widths and the cell control struct.
package xlb_pkg;

  localparam int OPERAND_BITS = 63;
  localparam int DEF_WORD_BITS = 63;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REDUCE = 2'd1,
    OP_MAX    = 2'd2,
    OP_KTH    = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic done;
    logic ok;
  } ctl_t;

endpackage

[hdl/xlb_cell.sv]
// One basis slot of the XOR linear basis chain and its stage register.
// Depends on xlb_pkg.
module xlb_cell #(
  parameter int W   = 63,
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  xlb_pkg::ctl_t                up_ctl,
  input  logic [W-1:0]                 up_v,
  input  logic [xlb_pkg::OPERAND_BITS-1:0] up_k,
  input  xlb_pkg::ctl_t                dn_ctl,
  input  logic [W-1:0]                 dn_v,
  input  logic [xlb_pkg::OPERAND_BITS-1:0] dn_k,
  input  logic [IW-1:0]                tgt,
  input  logic                         wr_en,
  input  logic [W-1:0]                 wr_data,
  output xlb_pkg::ctl_t                out_ctl,
  output logic [W-1:0]                 out_v,
  output logic [xlb_pkg::OPERAND_BITS-1:0] out_k,
  output logic [W-1:0]                 slot
);
  import xlb_pkg::*;

  ctl_t                    in_ctl;
  logic [W-1:0]            in_v;
  logic [OPERAND_BITS-1:0] in_k;
  ctl_t                    ctl_next;
  logic [W-1:0]            v_next;
  logic [OPERAND_BITS-1:0] k_next;
  logic                    store;
  logic [W-1:0]            x;

  always_comb begin
    if (up_ctl.valid && up_ctl.op != OP_KTH) begin
      in_ctl = up_ctl;
      in_v   = up_v;
      in_k   = up_k;
    end else if (dn_ctl.valid && dn_ctl.op == OP_KTH) begin
      in_ctl = dn_ctl;
      in_v   = dn_v;
      in_k   = dn_k;
    end else begin
      in_ctl = '0;
      in_v   = dn_v;
      in_k   = dn_k;
    end
    x        = in_v ^ slot;
    ctl_next = in_ctl;
    v_next   = in_v;
    k_next   = in_k;
    store    = 1'b0;
    if (in_ctl.valid && !in_ctl.done) begin
      unique case (in_ctl.op)
        OP_INSERT: begin
          if (in_v[IDX]) begin
            if (slot == '0) begin
              store         = 1'b1;
              ctl_next.done = 1'b1;
              ctl_next.ok   = 1'b1;
            end else begin
              v_next = x;
              if (x == '0) begin
                ctl_next.done = 1'b1;
                ctl_next.ok   = 1'b0;
              end
            end
          end
        end
        OP_REDUCE: begin
          if (IW'(IDX) < tgt && in_v[IDX]) begin
            v_next = x;
          end
        end
        OP_MAX: begin
          if (x > in_v) begin
            v_next = x;
          end
        end
        default: begin
          if (in_k != '0 && slot != '0) begin
            if (in_k[0]) begin
              v_next = x;
            end
            k_next = {1'b0, in_k[OPERAND_BITS-1:1]};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot          <= '0;
      out_ctl.valid <= 1'b0;
    end else begin
      if (store) begin
        slot <= in_v;
      end else if (wr_en && tgt == IW'(IDX)) begin
        slot <= wr_data;
      end
      out_ctl.valid <= ctl_next.valid;
    end
    out_ctl.op   <= ctl_next.op;
    out_ctl.done <= ctl_next.done;
    out_ctl.ok   <= ctl_next.ok;
    out_v        <= v_next;
    out_k        <= k_next;
  end

endmodule

[hdl/xor_linear_basis.sv]
// Top level of the GF(2) XOR linear basis block: cell chain and sequencer.
// Depends on xlb_pkg and xlb_cell.
//
// One transaction at a time. Insert, max and k-th return their result once
// the operand has walked the chain of basis cells, one cell per cycle
// (downward for insert and max, upward for k-th). Insert of zero and the
// trivial k-th cases answer in the cycle after the input transaction. Reduce
// runs WORD_BITS - 1 passes down the chain, one for each slot above slot 0,
// and its result comes when the last pass has left the chain. The result is
// held in an output register until taken, and the next input is taken the
// cycle after that.
module xor_linear_basis #(
  parameter int WORD_BITS = xlb_pkg::DEF_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // operand [62:0]
  input  logic [1:0]  s_tuser,  // op [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // result_value [62:0]
  output logic [0:0]  m_tuser   // ok [0]
);
  import xlb_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int IW = $clog2(W);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                  state;
  op_t                     op;
  logic [IW-1:0]           tgt;
  logic                    zero_reachable;
  ctl_t                    inj_ctl;
  logic [W-1:0]            inj_v;
  logic [OPERAND_BITS-1:0] inj_k;
  logic [OPERAND_BITS-1:0] res_val;
  logic                    res_ok;

  state_t                  state_next;
  op_t                     op_next;
  logic [IW-1:0]           tgt_next;
  logic                    zero_reachable_next;
  ctl_t                    inj_ctl_next;
  logic [W-1:0]            inj_v_next;
  logic [OPERAND_BITS-1:0] inj_k_next;
  logic [OPERAND_BITS-1:0] res_val_next;
  logic                    res_ok_next;

  ctl_t                    c_ctl [W];
  logic [W-1:0]            c_v   [W];
  logic [OPERAND_BITS-1:0] c_k   [W];
  logic [W-1:0]            c_slot[W];

  ctl_t                    end_ctl;
  logic [W-1:0]            end_v;
  logic [OPERAND_BITS-1:0] end_k;
  logic                    wr_en;
  logic [W-1:0]            in_word;
  logic [OPERAND_BITS-1:0] in_k;
  logic [OPERAND_BITS-1:0] k_adj;
  op_t                     in_op;

  assign in_word  = W'(s_tdata[OPERAND_BITS-1:0]);
  assign in_k     = s_tdata[OPERAND_BITS-1:0];
  assign in_op    = op_t'(s_tuser);
  assign k_adj    = zero_reachable ? in_k - OPERAND_BITS'(1) : in_k;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_DONE);
  assign m_tdata  = {1'b0, res_val};
  assign m_tuser  = res_ok;

  always_comb begin
    if (op == OP_KTH) begin
      end_ctl = c_ctl[W-1];
      end_v   = c_v[W-1];
      end_k   = c_k[W-1];
    end else begin
      end_ctl = c_ctl[0];
      end_v   = c_v[0];
      end_k   = c_k[0];
    end
  end

  assign wr_en = (state == S_RUN) && end_ctl.valid && op == OP_REDUCE;

  for (genvar i = 0; i < W; i++) begin : g_cell
    ctl_t                    up_ctl;
    logic [W-1:0]            up_v;
    logic [OPERAND_BITS-1:0] up_k;
    ctl_t                    dn_ctl;
    logic [W-1:0]            dn_v;
    logic [OPERAND_BITS-1:0] dn_k;

    if (i == W - 1) begin : g_top
      assign up_ctl = inj_ctl;
      assign up_v   = inj_v;
      assign up_k   = inj_k;
    end else begin : g_mid
      assign up_ctl = c_ctl[i+1];
      assign up_v   = c_v[i+1];
      assign up_k   = c_k[i+1];
    end
    if (i == 0) begin : g_bot
      assign dn_ctl = inj_ctl;
      assign dn_v   = inj_v;
      assign dn_k   = inj_k;
    end else begin : g_low
      assign dn_ctl = c_ctl[i-1];
      assign dn_v   = c_v[i-1];
      assign dn_k   = c_k[i-1];
    end

    xlb_cell #(.W(W), .IDX(i), .IW(IW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_ctl  (up_ctl),
      .up_v    (up_v),
      .up_k    (up_k),
      .dn_ctl  (dn_ctl),
      .dn_v    (dn_v),
      .dn_k    (dn_k),
      .tgt     (tgt),
      .wr_en   (wr_en),
      .wr_data (end_v),
      .out_ctl (c_ctl[i]),
      .out_v   (c_v[i]),
      .out_k   (c_k[i]),
      .slot    (c_slot[i])
    );
  end

  always_comb begin
    state_next          = state;
    op_next             = op;
    tgt_next            = tgt;
    zero_reachable_next = zero_reachable;
    inj_ctl_next        = '0;
    inj_v_next          = inj_v;
    inj_k_next          = inj_k;
    res_val_next        = res_val;
    res_ok_next         = res_ok;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next      = in_op;
          inj_k_next   = in_k;
          inj_v_next   = '0;
          inj_ctl_next = '{valid: 1'b1, op: in_op, done: 1'b0, ok: 1'b0};
          res_val_next = '0;
          res_ok_next  = 1'b1;
          state_next   = S_RUN;
          unique case (in_op)
            OP_INSERT: begin
              inj_v_next = in_word;
              if (in_word == '0) begin
                inj_ctl_next.valid  = 1'b0;
                zero_reachable_next = 1'b1;
                res_ok_next         = 1'b0;
                state_next          = S_DONE;
              end
            end
            OP_REDUCE: begin
              tgt_next   = IW'(W - 1);
              inj_v_next = c_slot[W-1];
            end
            OP_MAX: begin
            end
            default: begin
              inj_k_next = k_adj;
              if (zero_reachable && in_k == '0) begin
                inj_ctl_next.valid = 1'b0;
                res_ok_next        = 1'b0;
                state_next         = S_DONE;
              end else if (k_adj == '0) begin
                inj_ctl_next.valid = 1'b0;
                state_next         = S_DONE;
              end
            end
          endcase
        end
      end
      S_RUN: begin
        if (end_ctl.valid) begin
          unique case (op)
            OP_INSERT: begin
              res_ok_next = end_ctl.ok;
              if (!end_ctl.ok) begin
                zero_reachable_next = 1'b1;
              end
              state_next = S_DONE;
            end
            OP_REDUCE: begin
              if (tgt == IW'(1)) begin
                state_next = S_DONE;
              end else begin
                tgt_next     = tgt - IW'(1);
                inj_v_next   = c_slot[tgt - IW'(1)];
                inj_ctl_next = '{valid: 1'b1, op: OP_REDUCE, done: 1'b0, ok: 1'b0};
              end
            end
            OP_MAX: begin
              res_val_next = OPERAND_BITS'(end_v);
              state_next   = S_DONE;
            end
            default: begin
              if (end_k == '0) begin
                res_val_next = OPERAND_BITS'(end_v);
              end else begin
                res_ok_next = 1'b0;
              end
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      zero_reachable <= 1'b0;
      inj_ctl        <= '0;
    end else begin
      state          <= state_next;
      zero_reachable <= zero_reachable_next;
      inj_ctl        <= inj_ctl_next;
    end
    op      <= op_next;
    tgt     <= tgt_next;
    inj_v   <= inj_v_next;
    inj_k   <= inj_k_next;
    res_val <= res_val_next;
    res_ok  <= res_ok_next;
  end

endmodule

[bench/tb.sv]
// Testbench for xor_linear_basis: a scoreboard class predicts each result
// from its own copy of the basis and checks the output stream.
// Depends on xlb_pkg and the xor_linear_basis RTL.
module tb;
  import xlb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = DEF_WORD_BITS;
  localparam longint LIMIT = 1500000;

  class basis_scoreboard;
    bit [W-1:0] slot [W];
    bit         zero_hit;
    bit [62:0]  exp_value [$];
    bit         exp_ok [$];
    int         errors;

    function new();
      foreach (slot[i]) slot[i] = '0;
      zero_hit = 0;
      errors = 0;
    endfunction

    function void note(op_t op, bit [62:0] opnd);
      bit [W-1:0] v, acc;
      bit [62:0]  k;
      bit         ok, done;
      v = opnd[W-1:0];
      acc = '0;
      ok = 1;
      case (op)
        OP_INSERT: begin
          ok = 0;
          done = 0;
          if (v == 0) begin
            zero_hit = 1;
            done = 1;
          end
          for (int q = W - 1; q >= 0 && !done; q--) begin
            if (v[q]) begin
              if (slot[q] == 0) begin
                slot[q] = v;
                ok = 1;
                done = 1;
              end else begin
                v ^= slot[q];
                if (v == 0) begin
                  zero_hit = 1;
                  done = 1;
                end
              end
            end
          end
        end
        OP_REDUCE: begin
          for (int q = W - 1; q >= 0; q--)
            for (int p = q - 1; p >= 0; p--)
              if (slot[q][p]) slot[q] ^= slot[p];
        end
        OP_MAX: begin
          for (int q = W - 1; q >= 0; q--)
            if ((acc ^ slot[q]) > acc) acc ^= slot[q];
        end
        default: begin
          k = opnd;
          if (zero_hit && k == 0) ok = 0;
          else begin
            if (zero_hit) k -= 1;
            for (int q = 0; q < W && k != 0; q++) begin
              if (slot[q] != 0) begin
                if (k[0]) acc ^= slot[q];
                k >>= 1;
              end
            end
            if (k != 0) begin
              ok = 0;
              acc = '0;
            end
          end
        end
      endcase
      exp_value.push_back(63'(acc));
      exp_ok.push_back(ok);
    endfunction

    function void check(bit [62:0] value, bit ok);
      bit [62:0] ev;
      bit        eo;
      if (exp_value.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result value=%h ok=%0d", value, ok);
        return;
      end
      ev = exp_value.pop_front();
      eo = exp_ok.pop_front();
      if (ev !== value || eo !== ok) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value=%h ok=%0d, actual value=%h ok=%0d",
                   ev, eo, value, ok);
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        calm;
  longint      cycles;
  int          stall;

  basis_scoreboard sb = new();

  xor_linear_basis DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    m_tready = 0;
    stall = 0;
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check(m_tdata[62:0], m_tuser[0]);
    if (calm) m_tready <= 1;
    else if (stall > 0) begin
      stall <= stall - 1;
      m_tready <= 0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall <= gap_len();
      m_tready <= 0;
    end else m_tready <= 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("xor_linear_basis test failed");
      $finish;
    end
  end

  task automatic send(op_t op, bit [62:0] opnd);
    int g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {1'b0, opnd};
    do @(posedge clk); while (!s_tready);
    sb.note(op, opnd);
  endtask

  function automatic bit [62:0] sparse_word();
    bit [62:0] v;
    int w;
    v = 63'({$urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: v = 63'(1) << $urandom_range(0, 62);
      1: begin
        w = $urandom_range(1, 8);
        v = v & ((63'(1) << w) - 63'(1));
      end
      2: v = v & 63'({$urandom(), $urandom()}) & 63'({$urandom(), $urandom()});
      default: ;
    endcase
    return v;
  endfunction

  function automatic bit [62:0] rank_word();
    bit [62:0] v;
    v = 63'({$urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: return 63'($urandom_range(0, 4));
      1: return v & ((63'(1) << $urandom_range(1, 62)) - 63'(1));
      2: return 63'(1) << $urandom_range(0, 62);
      default: return v;
    endcase
  endfunction

  initial begin
    int r;
    cycles = 0;
    calm = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = OP_INSERT;
    repeat (3) @(posedge clk);
    rst <= 0;

    send(OP_KTH, 63'd0);
    send(OP_MAX, 63'd0);
    send(OP_KTH, 63'd1);
    send(OP_INSERT, 63'd1);
    send(OP_INSERT, '1);
    send(OP_INSERT, 63'(1) << 62);
    send(OP_KTH, '1);
    send(OP_KTH, 63'd3);
    send(OP_INSERT, 63'h3);
    send(OP_KTH, 63'd0);
    send(OP_INSERT, 63'd1);
    send(OP_KTH, 63'd0);
    send(OP_KTH, 63'd1);
    send(OP_KTH, 63'd2);
    send(OP_KTH, 63'd7);
    send(OP_KTH, 63'd8);
    send(OP_MAX, 63'd0);
    send(OP_REDUCE, '1);
    send(OP_MAX, 63'd0);
    send(OP_KTH, 63'd5);
    send(OP_INSERT, 63'd0);
    send(OP_INSERT, 63'h2AAA_AAAA_AAAA_AAAA);

    for (int i = 0; i < 450; i++) begin
      if (i % 100 == 50) calm = 1;
      if (i % 100 == 70) calm = 0;
      r = $urandom_range(0, 99);
      if (r < 45) send(OP_INSERT, sparse_word());
      else if (r < 78) send(OP_KTH, rank_word());
      else if (r < 95) send(OP_MAX, 63'({$urandom(), $urandom()}));
      else send(OP_REDUCE, 63'({$urandom(), $urandom()}));
    end
    s_tvalid <= 0;
    calm = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("xor_linear_basis test passed");
    else $display("xor_linear_basis test failed");
    $finish;
  end
endmodule

[files.f]
hdl/xlb_pkg.sv
hdl/xlb_cell.sv
hdl/xor_linear_basis.sv
bench/tb.sv
